/* sv/bffa_pkg.sv */
// Shared types and constants of the bitmap first-free allocator.
package bffa_pkg;

  // Item opcodes carried on the input tuser.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Fixed field widths.
  localparam int OPCODE_W    = 2;
  localparam int WORD_IDX_W  = 11;
  localparam int WORD_W      = 32;
  localparam int BIT_IDX_W   = 16;
  localparam int CFG_W       = 4;
  localparam int BIT_SEL_W   = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;     // write the input word into the map
    logic rd_issue;    // read the map at the input address
    logic scan_start;  // read word 0 and arm the scan pointer
    logic scan_next;   // read the word at the scan pointer and advance
    logic alloc_hit;   // set the lowest clear bit of the checked word
    logic res_miss;    // result is all zero
    logic out_load;    // move the result into the output register
  } bffa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;    // input word index lies inside the map
    logic limit_zero;  // no blocks to search
    logic word_full;   // checked word has no clear bit
    logic scan_last;   // checked word is the last one in the search range
    logic out_free;    // output register can take a result this cycle
  } bffa_sts_t;

endpackage

/* sv/bffa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bffa_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 2048,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bffa_dpath.sv */
// Datapath: bitmap memory, scan pointer, first-zero search, result and output registers.
module bffa_dpath
  import bffa_pkg::*;
#(
  parameter int BLOCK_BYTES = 1024,
  parameter int MAP_BLOCKS  = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic [WORD_IDX_W-1:0]   word_index_i,
  input  logic [WORD_W-1:0]       word_value_i,
  input  bffa_cmd_t               cmd_i,
  output bffa_sts_t               sts_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [BIT_IDX_W-1:0]    bit_index_o,
  output logic                    found_o,
  output logic [WORD_W-1:0]       read_value_o
);

  localparam int WPB         = BLOCK_BYTES / 4;
  localparam int TOTAL_WORDS = MAP_BLOCKS * WPB;
  localparam int AW          = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int CW          = $clog2(TOTAL_WORDS + 1);

  logic [CW-1:0]        limit_q, limit_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        chk_addr_q, chk_addr_d;
  logic [BIT_IDX_W-1:0] res_idx_q, res_idx_d;
  logic                 res_found_q, res_found_d;
  logic                 res_rd_q, res_rd_d;
  logic                 out_valid_q, out_valid_d;
  logic [BIT_IDX_W-1:0] out_idx_q;
  logic                 out_found_q;
  logic [WORD_W-1:0]    out_val_q;

  logic [AW-1:0]        in_addr;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;
  logic [BIT_SEL_W-1:0] free_bit;
  logic [WORD_W-1:0]    set_mask;

  assign in_addr = AW'(word_index_i);

  // Saturate the block count and turn it into a word limit.
  always_comb begin
    int unsigned blk;
    blk = 32'(cfg_data_i);
    if (blk > MAP_BLOCKS) begin
      blk = MAP_BLOCKS;
    end
    limit_d = limit_q;
    if (cfg_valid_i) begin
      limit_d = CW'(blk * WPB);
    end
  end

  // Lowest clear bit of the checked word.
  always_comb begin
    free_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        free_bit = BIT_SEL_W'(i);
      end
    end
  end

  assign set_mask = WORD_W'(1) << free_bit;

  // Memory port steering.
  always_comb begin
    ram_we    = cmd_i.load_wr | cmd_i.alloc_hit;
    ram_waddr = cmd_i.alloc_hit ? chk_addr_q : in_addr;
    ram_wdata = cmd_i.alloc_hit ? (ram_rdata | set_mask) : word_value_i;
    ram_re    = cmd_i.rd_issue | cmd_i.scan_start | cmd_i.scan_next;
    if (cmd_i.rd_issue) begin
      ram_raddr = in_addr;
    end else if (cmd_i.scan_start) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = AW'(ptr_q);
    end
  end

  bffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TOTAL_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Scan pointer: ptr_q is the next word to read, chk_addr_q the word now at the RAM output.
  always_comb begin
    ptr_d      = ptr_q;
    chk_addr_d = chk_addr_q;
    if (cmd_i.scan_start) begin
      ptr_d      = CW'(1);
      chk_addr_d = '0;
    end else if (cmd_i.scan_next) begin
      ptr_d      = ptr_q + CW'(1);
      chk_addr_d = AW'(ptr_q);
    end
  end

  // Result staging.
  always_comb begin
    res_idx_d   = res_idx_q;
    res_found_d = res_found_q;
    res_rd_d    = res_rd_q;
    if (cmd_i.rd_issue) begin
      res_idx_d   = '0;
      res_found_d = 1'b0;
      res_rd_d    = 1'b1;
    end else if (cmd_i.res_miss) begin
      res_idx_d   = '0;
      res_found_d = 1'b0;
      res_rd_d    = 1'b0;
    end else if (cmd_i.alloc_hit) begin
      res_idx_d   = BIT_IDX_W'({chk_addr_q, free_bit});
      res_found_d = 1'b1;
      res_rd_d    = 1'b0;
    end
  end

  assign out_valid_d = cmd_i.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '0;
      ptr_q       <= '0;
      chk_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      ptr_q       <= ptr_d;
      chk_addr_q  <= chk_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q   <= res_idx_d;
    res_found_q <= res_found_d;
    res_rd_q    <= res_rd_d;
    if (cmd_i.out_load) begin
      out_idx_q   <= res_idx_q;
      out_found_q <= res_found_q;
      out_val_q   <= res_rd_q ? ram_rdata : '0;
    end
  end

  assign sts_o.in_range   = (32'(word_index_i) < 32'(TOTAL_WORDS));
  assign sts_o.limit_zero = (limit_q == '0);
  assign sts_o.word_full  = &ram_rdata;
  assign sts_o.scan_last  = (ptr_q == limit_q);
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign bit_index_o  = out_idx_q;
  assign found_o      = out_found_q;
  assign read_value_o = out_val_q;

  // The scan never reads past the configured range.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_next |-> ptr_q < limit_q)
    else $error("scan pointer beyond limit");

  // An allocation only marks a word inside the searched range.
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_hit |-> CW'(chk_addr_q) < limit_q)
    else $error("allocation outside searched range");

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> sts_o.out_free)
    else $error("output register overwritten");

endmodule

/* sv/bffa_ctrl.sv */
// Controller state machine: item decode, word scan sequencing, result hand-off.
module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  output logic                in_ready_o,
  input  bffa_sts_t           sts_i,
  output bffa_cmd_t           cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (opcode_i)
            OP_LOAD: begin
              cmd_o.load_wr = sts_i.in_range;
            end
            OP_ALLOC: begin
              if (sts_i.limit_zero) begin
                cmd_o.res_miss = 1'b1;
                state_d        = ST_RESP;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = ST_SCAN;
              end
            end
            OP_READ: begin
              cmd_o.rd_issue = sts_i.in_range;
              cmd_o.res_miss = ~sts_i.in_range;
              state_d        = ST_RESP;
            end
            default: begin
              // drop unused opcode
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!sts_i.word_full) begin
          cmd_o.alloc_hit = 1'b1;
          state_d         = ST_RESP;
        end else if (sts_i.scan_last) begin
          cmd_o.res_miss = 1'b1;
          state_d        = ST_RESP;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // At most one datapath action per cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_wr, cmd_o.rd_issue, cmd_o.scan_start, cmd_o.scan_next,
              cmd_o.alloc_hit, cmd_o.res_miss, cmd_o.out_load}))
    else $error("conflicting datapath commands");

  // Handing off a result returns to idle.
  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == ST_IDLE)
    else $error("controller did not return to idle");

  // A scan is always entered through a start command.
  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && $past(state_q) == ST_IDLE) |-> $past(cmd_o.scan_start))
    else $error("scan entered without start");

endmodule

/* sv/bitmap_first_free_allocator_core.sv */
// Top level of the bitmap first-free allocator.
//
// Usage:
//   Write blocks_in_use on the cfg channel (cfg_valid_i/cfg_ready_o) while the block is
//   idle; cfg_ready_o is always high. Items arrive on s_axis: tuser holds the opcode
//   (load word, allocate, read word), tdata the word index and the word value. Load every
//   word of the blocks in use before the first allocate or read.
//   Results leave on m_axis: bit_index, found and read_value in tdata. Loads and unused
//   opcodes give no result.
// Sequencing:
//   A load writes its word as it is taken. A read or an allocate holds off new items
//   until its result moves into the output register. An allocate checks 1 up to
//   min(blocks_in_use, MAP_BLOCKS) * BLOCK_BYTES / 4 words; the single read port of the
//   bitmap RAM sets the pace of one word per cycle. With no blocks in use none is checked.
// Reset:
//   rst_ni clears the controller, the output valid and blocks_in_use (so the map counts
//   as full). The bitmap RAM is not cleared; its contents are undefined until loaded.
// Back-pressure:
//   One output register holds a finished result; the next item is taken while it waits,
//   and the block stalls only when a second result is ready before the first transfer.
module bitmap_first_free_allocator_core
  import bffa_pkg::*;
#(
  parameter int BLOCK_BYTES = 1024,
  parameter int MAP_BLOCKS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write: blocks_in_use
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // word_index[10:0], word_value[42:11]
  input  logic [OPCODE_W-1:0]    s_axis_tuser,   // opcode[1:0]
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // bit_index[15:0], found[16],
                                                 // read_value[48:17]
);

  localparam int VAL_LSB = WORD_IDX_W;
  localparam int RV_LSB  = BIT_IDX_W + 1;
  localparam int PAD_W   = OUT_TDATA_W - RV_LSB - WORD_W;

  bffa_cmd_t             cmd;
  bffa_sts_t             sts;
  logic [BIT_IDX_W-1:0]  bit_index;
  logic                  found;
  logic [WORD_W-1:0]     read_value;
  logic                  cfg_wr;

  // Configuration is taken on every cycle; only valid gates the write.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  bffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bffa_dpath #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAP_BLOCKS  (MAP_BLOCKS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_wr),
    .cfg_data_i   (cfg_data_i),
    .word_index_i (s_axis_tdata[WORD_IDX_W-1:0]),
    .word_value_i (s_axis_tdata[VAL_LSB +: WORD_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .bit_index_o  (bit_index),
    .found_o      (found),
    .read_value_o (read_value)
  );

  // Pack the result, padding to whole bytes.
  assign m_axis_tdata = {{PAD_W{1'b0}}, read_value, found, bit_index};

endmodule

/* tb/bitmap_alloc_checker.sv */
// Checker for the bitmap first-free allocator: mirrors the map and compares every result.
`timescale 1ns / 100ps

module bitmap_alloc_checker
  import bffa_pkg::*;
#(
  parameter int BLOCK_BYTES = 1024,
  parameter int MAP_BLOCKS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,   // word_index[10:0], word_value[42:11]
  input  logic [OPCODE_W-1:0]    s_tuser_i,   // opcode[1:0]
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,   // bit_index[15:0], found[16], read_value[48:17]
  output int                     pending_o,
  output int                     fail_count_o
);

  localparam int WORDS_PER_BLOCK = BLOCK_BYTES / 4;
  localparam int MAP_WORDS       = MAP_BLOCKS * WORDS_PER_BLOCK;

  typedef struct packed {
    logic [BIT_IDX_W-1:0] bit_index;
    logic                 found;
    logic [WORD_W-1:0]    read_value;
  } map_result_t;

  logic [WORD_W-1:0] map_words [MAP_WORDS];
  logic [CFG_W-1:0]  blocks_cfg;
  map_result_t       due_results [$];
  int                fail_tally;

  assign fail_count_o = fail_tally;

  // Apply one item to the mirrored map; return 1 when the item yields a result.
  function automatic bit map_respond(input logic [OPCODE_W-1:0] op,
                                     input logic [WORD_IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] val,
                                     output map_result_t res);
    int unsigned span;
    int unsigned w;
    int unsigned b;
    bit          hit;
    res = '0;
    case (op)
      OP_LOAD: begin
        if (idx < MAP_WORDS) map_words[idx] = val;
        return 1'b0;
      end
      OP_ALLOC: begin
        span = (blocks_cfg > MAP_BLOCKS) ? MAP_BLOCKS : blocks_cfg;
        span = span * WORDS_PER_BLOCK;
        hit  = 1'b0;
        for (w = 0; w < span && !hit; w++) begin
          if (map_words[w] != '1) begin
            b = 0;
            while (b < 31 && map_words[w][b]) b++;
            map_words[w][b] = 1'b1;
            res.bit_index   = BIT_IDX_W'(w * 32 + b);
            res.found       = 1'b1;
            hit             = 1'b1;
          end
        end
        return 1'b1;
      end
      OP_READ: begin
        if (idx < MAP_WORDS) res.read_value = map_words[idx];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    map_result_t got;
    map_result_t want;
    map_result_t fresh;
    if (!rst_ni) begin
      foreach (map_words[i]) map_words[i] = '0;
      blocks_cfg = '0;
      due_results.delete();
      fail_tally = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) blocks_cfg = cfg_data_i;
      // Compare the outgoing transfer before taking in a new item.
      if (m_tvalid_i && m_tready_i) begin
        got.bit_index  = m_tdata_i[15:0];
        got.found      = m_tdata_i[16];
        got.read_value = m_tdata_i[48:17];
        if (due_results.size() == 0) begin
          $error("result with no expectation waiting: tdata %h", m_tdata_i);
          fail_tally++;
        end else begin
          want = due_results.pop_front();
          if (got.bit_index != want.bit_index) begin
            $error("bit_index: expected %0d, got %0d", want.bit_index, got.bit_index);
            fail_tally++;
          end
          if (got.found != want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_tally++;
          end
          if (got.read_value != want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            fail_tally++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (map_respond(s_tuser_i, s_tdata_i[10:0], s_tdata_i[42:11], fresh))
          due_results.push_back(fresh);
      end
      pending_o <= due_results.size();
    end
  end

endmodule

/* tb/bitmap_first_free_allocator_core_test.sv */
// Stimulus and verdict for the bitmap first-free allocator core.
`timescale 1ns / 100ps

module bitmap_first_free_allocator_core_test;
  import bffa_pkg::*;

  localparam int BLOCK_BYTES     = 1024;
  localparam int MAP_BLOCKS      = 8;
  localparam int WORDS_PER_BLOCK = BLOCK_BYTES / 4;
  localparam int MAP_WORDS       = MAP_BLOCKS * WORDS_PER_BLOCK;
  // Only the first block is loaded in full, and a run of clear words inside it keeps every
  // scan from leaving it; no other word is read or scanned.
  localparam int RESERVE_LO      = 192;
  localparam int RESERVE_WORDS   = 16;
  // A scan never leaves the first block; a few hundred items with long gaps and long
  // output stalls stay far below this.
  localparam int CYCLE_LIMIT     = 1_000_000;
  // Loads give no result, so hold this long after the last result before a register write.
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_ITEMS     = 32;
  localparam int PHASE_COUNT     = 6;
  // blocks_in_use per random phase, phase 0 in the low nibble: full map, one block,
  // saturated, none, a middle value and just above the map size.
  localparam logic [4*PHASE_COUNT-1:0] PHASE_BLOCKS = {4'd9, 4'd5, 4'd0, 4'd15, 4'd1, 4'd8};
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0]   FULL_WORD = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // word_index[10:0], word_value[42:11]
  logic [OPCODE_W-1:0]    s_axis_tuser;   // opcode[1:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // bit_index[15:0], found[16], read_value[48:17]

  int dut_pending;
  int fail_count;
  int cycle_count = 0;
  bit tx_steady   = 1'b0;  // sender runs without gaps while set
  bit rx_steady   = 1'b0;  // receiver never stalls while set
  int stall_left  = 0;
  int rx_pick;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bitmap_first_free_allocator_core #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAP_BLOCKS  (MAP_BLOCKS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bitmap_alloc_checker #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAP_BLOCKS  (MAP_BLOCKS)
  ) map_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .pending_o    (dut_pending),
    .fail_count_o (fail_count)
  );

  // Result side back-pressure: mostly short stalls, now and then a long one, and
  // stretches with no stall at all whenever rx_steady flips on.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_steady) begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 20) stall_left = $urandom_range(1, 3);
        else if (rx_pick < 24) stall_left = $urandom_range(15, 60);
      end
    end
  end

  // Hard stop in case the block hangs or a result never shows up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Word contents with a bias toward full words and words with a single hole, so that
  // scans run past several words before they hit.
  function automatic logic [WORD_W-1:0] map_value();
    logic [WORD_W-1:0] v;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    v    = FULL_WORD;
    if (pick == 4 || pick == 5) v[$urandom_range(0, 31)] = 1'b0;
    else if (pick == 6 || pick == 7) v = $urandom;
    else if (pick == 8) v = '0;
    else if (pick == 9) v = $urandom & $urandom & $urandom;
    return v;
  endfunction

  // Present one item and hold it until the transfer; then maybe drop valid for a gap.
  // With no gap, valid stays high and the next call only updates the payload.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [WORD_IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] val);
    int pick;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W - WORD_IDX_W - WORD_W){1'b0}}, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!tx_steady) begin
      pick = $urandom_range(0, 99);
      gap  = (pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid and wait until every expected result has gone out and any trailing
  // load has retired. Step past a clock edge first so the checker has counted the last item.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (dut_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_blocks(input logic [CFG_W-1:0] blocks);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= blocks;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int                    ph;
    int                    w;
    int                    run;
    int                    made;
    int                    pick;
    logic [WORD_IDX_W-1:0] idx;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOAD;
    m_axis_tready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. blocks_in_use comes out of reset as 0: search nothing, map full.
    send_item(OP_ALLOC, '1, FULL_WORD);
    // Unused opcode: must be swallowed without a result.
    send_item(OP_UNUSED, '1, FULL_WORD);
    write_blocks(4'd1);

    // Load the first block: all full except the top bit of its last word, which makes the
    // first allocate walk every word of the block and return its highest index.
    tx_steady = 1'b1;
    for (w = 0; w < WORDS_PER_BLOCK; w++)
      send_item(OP_LOAD, WORD_IDX_W'(w), (w == WORDS_PER_BLOCK - 1) ? 32'h7FFF_FFFF : FULL_WORD);
    tx_steady = 1'b0;
    send_item(OP_ALLOC, '0, '0);                     // last bit of the block
    send_item(OP_ALLOC, '0, '0);                     // now full: no bit found
    send_item(OP_READ, WORD_IDX_W'(WORDS_PER_BLOCK - 1), '0);
    send_item(OP_READ, '0, '0);
    send_item(OP_LOAD, '0, '0);                      // empty first word
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_LOAD, '0, 32'h7FFF_FFFF);           // only the top bit of word 0 free
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_LOAD, 11'd5, 32'hFFFF_FFFE);        // first hole a few words in
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_LOAD, 11'd3, '0);
    send_item(OP_READ, 11'd3, FULL_WORD);
    send_item(OP_LOAD, 11'd3, FULL_WORD);
    send_item(OP_READ, 11'd3, '0);
    // A register value above the map size; the hole near the top of the first block
    // stops the scan before it leaves the loaded words.
    write_blocks('1);
    send_item(OP_LOAD, WORD_IDX_W'(WORDS_PER_BLOCK - 1), 32'hBFFF_FFFF);
    send_item(OP_ALLOC, '0, '0);
    write_blocks(4'd1);
    send_item(OP_ALLOC, '0, '0);                     // first block full
    // Clear a run of words high in the first block; no later load touches them.
    for (w = RESERVE_LO; w < RESERVE_LO + RESERVE_WORDS; w++)
      send_item(OP_LOAD, WORD_IDX_W'(w), '0);

    // Random part, one phase per register setting.
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      write_blocks(PHASE_BLOCKS[ph*4 +: 4]);
      // Refresh the bottom of the map so that allocations land at varying depths.
      run = $urandom_range(4, 15);
      for (w = 0; w <= run; w++) send_item(OP_LOAD, WORD_IDX_W'(w), map_value());
      made = 0;
      while (made < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        if ($urandom_range(0, 49) == 0) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_item(OP_UNUSED, WORD_IDX_W'($urandom), $urandom);
        end else if (pick < 38) begin
          // Keep loads off the cleared run so that every scan stops inside the first block.
          if ($urandom_range(0, 9) < 7) idx = WORD_IDX_W'($urandom_range(0, 63));
          else idx = WORD_IDX_W'($urandom_range(WORDS_PER_BLOCK, MAP_WORDS - 1));
          send_item(OP_LOAD, idx, map_value());
          made++;
        end else if (pick < 72) begin
          send_item(OP_ALLOC, WORD_IDX_W'($urandom), $urandom);
          made++;
        end else if (pick < 96) begin
          // Read only words of the first block, all of them loaded.
          if ($urandom_range(0, 9) < 7) idx = WORD_IDX_W'($urandom_range(0, 63));
          else idx = WORD_IDX_W'($urandom_range(0, WORDS_PER_BLOCK - 1));
          send_item(OP_READ, idx, $urandom);
          made++;
        end else begin
          // Fill a run of words from the bottom, then allocate past it.
          run = $urandom_range(1, 64);
          for (w = 0; w < run; w++) send_item(OP_LOAD, WORD_IDX_W'(w), FULL_WORD);
          send_item(OP_ALLOC, '0, '0);
          made += run + 1;
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
